FILE: src/prc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prc_pkg;

    // ring geometry; the ring depth is a power of two so slot and read
    // addresses wrap by masking
    localparam int RING_FRAMES = 1024;
    localparam int FRAME_BITS  = 32;
    localparam int MAX_READ    = 64;

    localparam int RING_BITS  = $clog2(RING_FRAMES);
    localparam int STORE_BITS = (FRAME_BITS < 32) ? FRAME_BITS : 32;
    localparam int CNT_W      = $clog2(MAX_READ + 1);
    localparam int AVAIL_W    = $clog2(RING_FRAMES + 1);

    // item field widths
    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 10;
    localparam int FRAME_W  = 32;
    localparam int WIDE_W   = 64;
    localparam int COUNT_W  = 7;
    localparam int CTR_W    = 32;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_PRODUCER_TIMEOUT = 1'b0;
    localparam logic [31:0] TIMEOUT_RESET = 32'd5000000;

    localparam logic [63:0] SKIP_LIMIT = 64'h0000_0000_7FFF_FFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_STORE   = 3'd0,
        CMD_PUBLISH = 3'd1,
        CMD_READ    = 3'd2,
        CMD_OPEN    = 3'd3,
        CMD_CLOSE   = 3'd4
    } cmd_t;

    typedef logic [RING_BITS-1:0]  ring_addr_t;
    typedef logic [STORE_BITS-1:0] store_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [AVAIL_W-1:0]    avail_t;

endpackage

`default_nettype wire

FILE: src/prc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface prc_in_if;
    logic                         valid;
    logic                         ready;
    logic [prc_pkg::CMD_W-1:0]    command;
    logic [prc_pkg::SLOT_W-1:0]   slot;
    logic [prc_pkg::FRAME_W-1:0]  frame_in;
    logic [prc_pkg::WIDE_W-1:0]   write_index;
    logic [prc_pkg::WIDE_W-1:0]   heartbeat;
    logic [prc_pkg::COUNT_W-1:0]  frame_count;
    logic [prc_pkg::WIDE_W-1:0]   now;

    modport source (
        output valid, command, slot, frame_in, write_index, heartbeat, frame_count, now,
        input  ready
    );
    modport sink (
        input  valid, command, slot, frame_in, write_index, heartbeat, frame_count, now,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/prc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface prc_out_if;
    logic                         valid;
    logic                         ready;
    logic [prc_pkg::FRAME_W-1:0]  frame_out;
    logic                         frame_real;
    logic                         last;
    logic [prc_pkg::COUNT_W-1:0]  real_frames;
    logic [prc_pkg::CTR_W-1:0]    underrun_count;
    logic [prc_pkg::CTR_W-1:0]    overrun_count;
    logic [prc_pkg::WIDE_W-1:0]   frames_delivered;
    logic                         stream_open;

    modport source (
        output valid, frame_out, frame_real, last, real_frames, underrun_count,
               overrun_count, frames_delivered, stream_open,
        input  ready
    );
    modport sink (
        input  valid, frame_out, frame_real, last, real_frames, underrun_count,
               overrun_count, frames_delivered, stream_open,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/pcm_ring_consumer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// pcm ring consumer: a producer stores frames into a 1024-slot ring and publishes
// its write index and a heartbeat; a read command drains up to 64 frames, one
// result item per frame, with silence substituted for missing data and for a dead
// producer, and the underrun, overrun and delivered counters carried on every
// result. After reset the ring is swept to zero, one slot per cycle, so the input
// stays not-ready until all slots are cleared (configuration writes are taken during
// the sweep). A read of n frames passes through the CHECK, PLAN and UPDATE states
// of 64-bit liveness and index arithmetic and then the registered ring memory read,
// and its frames enter the output register one frame per cycle while the output is
// not held off, paced by the single read port of the ring memory. Every other
// command, and a read of zero frames, gives one status item by the same ring read
// stage and output register. The output register lets the next item be accepted
// while the final result is still waiting to be taken; holding off the output
// while a result waits stalls the block.
module pcm_ring_consumer_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [prc_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [prc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [prc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    // item channels
    prc_in_if.sink                                 item_in,
    prc_out_if.source                              item_out
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_PLAN,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // control
    state_t               state_reg, state_next;
    prc_pkg::ring_addr_t  clr_idx_reg, clr_idx_next;
    prc_pkg::cnt_t        count_reg, count_next;
    prc_pkg::cnt_t        nreal_reg, nreal_next;
    prc_pkg::cnt_t        issue_idx_reg, issue_idx_next;

    // block state
    logic [31:0]          timeout_reg, timeout_next;
    logic [63:0]          read_pos_reg, read_pos_next;
    logic [63:0]          write_pos_reg, write_pos_next;
    logic [63:0]          last_beat_reg, last_beat_next;
    logic [31:0]          underruns_reg, underruns_next;
    logic [31:0]          overruns_reg, overruns_next;
    logic [63:0]          delivered_reg, delivered_next;
    logic                 open_reg, open_next;

    // read working registers
    prc_pkg::cnt_t        n_reg, n_next;
    logic [63:0]          now_reg, now_next;
    logic [64:0]          age_reg, age_next;
    logic [64:0]          diff_reg, diff_next;
    logic                 alive_reg, alive_next;
    logic                 lapped_reg, lapped_next;
    prc_pkg::avail_t      avail_reg, avail_next;
    logic [30:0]          skip_sat_reg, skip_sat_next;
    logic [63:0]          base_reg, base_next;

    // stage behind the ring read port
    logic                 q_valid_reg, q_valid_next;
    logic                 q_real_reg, q_real_next;
    logic                 q_last_reg, q_last_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          out_frame_reg, out_frame_next;
    logic                 out_real_reg, out_real_next;
    logic                 out_last_reg, out_last_next;
    logic [6:0]           out_nreal_reg, out_nreal_next;
    logic [31:0]          out_under_reg, out_under_next;
    logic [31:0]          out_over_reg, out_over_next;
    logic [63:0]          out_deliv_reg, out_deliv_next;
    logic                 out_open_reg, out_open_next;

    // ring memory ports
    logic                 ram_we;
    prc_pkg::ring_addr_t  ram_waddr;
    prc_pkg::store_t      ram_wdata;
    logic                 ram_re;
    prc_pkg::ring_addr_t  ram_raddr;
    prc_pkg::store_t      ram_rdata;

    logic                 accept;
    logic                 cfg_write;
    logic                 q_move;
    logic                 issue;
    prc_pkg::cnt_t        n_sat;
    prc_pkg::cnt_t        nreal_calc;
    logic                 wp_ge;
    logic [63:0]          skip;

    prc_ram #(
        .WIDTH (prc_pkg::STORE_BITS),
        .DEPTH (prc_pkg::RING_FRAMES)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pready         = 1'b1;
    assign cfg_write      = psel && penable && pwrite;
    assign prdata         = (paddr[2] == prc_pkg::REG_PRODUCER_TIMEOUT) ? timeout_reg : '0;

    assign item_in.ready  = (state_reg == ST_IDLE);
    assign accept         = item_in.valid && item_in.ready;

    assign item_out.valid            = out_valid_reg;
    assign item_out.frame_out        = out_frame_reg;
    assign item_out.frame_real       = out_real_reg;
    assign item_out.last             = out_last_reg;
    assign item_out.real_frames      = out_nreal_reg;
    assign item_out.underrun_count   = out_under_reg;
    assign item_out.overrun_count    = out_over_reg;
    assign item_out.frames_delivered = out_deliv_reg;
    assign item_out.stream_open      = out_open_reg;

    // requested count saturated to the largest read
    assign n_sat = (item_in.frame_count > prc_pkg::COUNT_W'(prc_pkg::MAX_READ))
                 ? prc_pkg::cnt_t'(prc_pkg::MAX_READ)
                 : prc_pkg::cnt_t'(item_in.frame_count);

    // frame hand-off from the ring read stage into the output register
    assign q_move = q_valid_reg && (!out_valid_reg || item_out.ready);
    assign issue  = (state_reg == ST_EMIT) && (issue_idx_reg < count_reg)
                 && (!q_valid_reg || q_move);

    // index arithmetic used in the plan step
    assign wp_ge = !diff_reg[64];
    assign skip  = diff_reg[63:0] - 64'(prc_pkg::RING_FRAMES);

    // real frames of a live read: the smaller of request and availability
    assign nreal_calc = (32'(n_reg) < 32'(avail_reg)) ? n_reg : prc_pkg::cnt_t'(avail_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        count_next     = count_reg;
        nreal_next     = nreal_reg;
        issue_idx_next = issue_idx_reg;

        timeout_next   = timeout_reg;
        read_pos_next  = read_pos_reg;
        write_pos_next = write_pos_reg;
        last_beat_next = last_beat_reg;
        underruns_next = underruns_reg;
        overruns_next  = overruns_reg;
        delivered_next = delivered_reg;
        open_next      = open_reg;

        n_next         = n_reg;
        now_next       = now_reg;
        age_next       = age_reg;
        diff_next      = diff_reg;
        alive_next     = alive_reg;
        lapped_next    = lapped_reg;
        avail_next     = avail_reg;
        skip_sat_next  = skip_sat_reg;
        base_next      = base_reg;

        q_valid_next   = q_valid_reg;
        q_real_next    = q_real_reg;
        q_last_next    = q_last_reg;

        out_valid_next = out_valid_reg;
        out_frame_next = out_frame_reg;
        out_real_next  = out_real_reg;
        out_last_next  = out_last_reg;
        out_nreal_next = out_nreal_reg;
        out_under_next = out_under_reg;
        out_over_next  = out_over_reg;
        out_deliv_next = out_deliv_reg;
        out_open_next  = out_open_reg;

        ram_we    = 1'b0;
        ram_waddr = clr_idx_reg;
        ram_wdata = '0;
        ram_re    = issue;
        ram_raddr = prc_pkg::ring_addr_t'(base_reg[prc_pkg::RING_BITS-1:0]
                  + prc_pkg::ring_addr_t'(issue_idx_reg));

        if (cfg_write && (paddr[2] == prc_pkg::REG_PRODUCER_TIMEOUT))
        begin
            timeout_next = pwdata;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero sweep of the ring after reset
                ram_we       = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == prc_pkg::ring_addr_t'(prc_pkg::RING_FRAMES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    // default: a single status item
                    count_next     = prc_pkg::cnt_t'(1);
                    nreal_next     = '0;
                    issue_idx_next = '0;
                    state_next     = ST_EMIT;
                    unique case (prc_pkg::cmd_t'(item_in.command))
                        prc_pkg::CMD_STORE:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = prc_pkg::ring_addr_t'(item_in.slot);
                            ram_wdata = prc_pkg::store_t'(item_in.frame_in);
                        end
                        prc_pkg::CMD_PUBLISH:
                        begin
                            write_pos_next = item_in.write_index;
                            last_beat_next = item_in.heartbeat;
                        end
                        prc_pkg::CMD_OPEN:
                        begin
                            open_next     = 1'b1;
                            read_pos_next = write_pos_reg;
                        end
                        prc_pkg::CMD_CLOSE:
                        begin
                            open_next = 1'b0;
                        end
                        prc_pkg::CMD_READ:
                        begin
                            if (n_sat != '0)
                            begin
                                n_next     = n_sat;
                                now_next   = item_in.now;
                                state_next = ST_CHECK;
                            end
                        end
                        default:
                        begin
                            // unknown command: status only
                        end
                    endcase
                end
            end

            ST_CHECK:
            begin
                // heartbeat age and ring fill, borrow in the top bit
                age_next   = {1'b0, now_reg} - {1'b0, last_beat_reg};
                diff_next  = {1'b0, write_pos_reg} - {1'b0, read_pos_reg};
                state_next = ST_PLAN;
            end

            ST_PLAN:
            begin
                alive_next  = (last_beat_reg != '0) && !age_reg[64]
                           && (age_reg[63:0] < {32'd0, timeout_reg});
                lapped_next = wp_ge && (diff_reg[63:0] > 64'(prc_pkg::RING_FRAMES));
                if (!wp_ge)
                begin
                    avail_next = '0;
                end
                else if (diff_reg[63:0] > 64'(prc_pkg::RING_FRAMES))
                begin
                    avail_next = prc_pkg::avail_t'(prc_pkg::RING_FRAMES);
                end
                else
                begin
                    avail_next = prc_pkg::avail_t'(diff_reg[63:0]);
                end
                skip_sat_next = (skip > prc_pkg::SKIP_LIMIT) ? 31'h7FFF_FFFF : skip[30:0];
                // a lapped reader jumps to the oldest frame still in the ring
                base_next  = (wp_ge && (diff_reg[63:0] > 64'(prc_pkg::RING_FRAMES)))
                           ? write_pos_reg - 64'(prc_pkg::RING_FRAMES)
                           : read_pos_reg;
                state_next = ST_UPDATE;
            end

            ST_UPDATE:
            begin
                count_next     = n_reg;
                issue_idx_next = '0;
                if (!alive_reg)
                begin
                    // dead producer: all silence, read position untouched
                    underruns_next = underruns_reg + 32'(n_reg);
                    nreal_next     = '0;
                end
                else
                begin
                    underruns_next = underruns_reg + 32'(n_reg - nreal_calc);
                    if (lapped_reg)
                    begin
                        overruns_next = overruns_reg + {1'b0, skip_sat_reg};
                    end
                    read_pos_next  = base_reg + 64'(n_reg);
                    delivered_next = delivered_reg + 64'(n_reg);
                    nreal_next     = nreal_calc;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (issue)
                begin
                    q_valid_next   = 1'b1;
                    q_real_next    = (issue_idx_reg < nreal_reg);
                    q_last_next    = (issue_idx_reg == count_reg - 1'b1);
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                else if (q_move)
                begin
                    q_valid_next = 1'b0;
                end
                if ((issue_idx_reg == count_reg) && !q_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // output register, loaded with the counters as they stand after the item
        if (q_move)
        begin
            out_valid_next = 1'b1;
            out_frame_next = q_real_reg ? 32'(ram_rdata) : 32'd0;
            out_real_next  = q_real_reg;
            out_last_next  = q_last_reg;
            out_nreal_next = 7'(nreal_reg);
            out_under_next = underruns_reg;
            out_over_next  = overruns_reg;
            out_deliv_next = delivered_reg;
            out_open_next  = open_reg;
        end
        else if (item_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            count_reg      <= '0;
            nreal_reg      <= '0;
            issue_idx_reg  <= '0;
            timeout_reg    <= prc_pkg::TIMEOUT_RESET;
            read_pos_reg   <= '0;
            write_pos_reg  <= '0;
            last_beat_reg  <= '0;
            underruns_reg  <= '0;
            overruns_reg   <= '0;
            delivered_reg  <= '0;
            open_reg       <= 1'b0;
            n_reg          <= '0;
            now_reg        <= '0;
            age_reg        <= '0;
            diff_reg       <= '0;
            alive_reg      <= 1'b0;
            lapped_reg     <= 1'b0;
            avail_reg      <= '0;
            skip_sat_reg   <= '0;
            base_reg       <= '0;
            q_valid_reg    <= 1'b0;
            q_real_reg     <= 1'b0;
            q_last_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_frame_reg  <= '0;
            out_real_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
            out_nreal_reg  <= '0;
            out_under_reg  <= '0;
            out_over_reg   <= '0;
            out_deliv_reg  <= '0;
            out_open_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            count_reg      <= count_next;
            nreal_reg      <= nreal_next;
            issue_idx_reg  <= issue_idx_next;
            timeout_reg    <= timeout_next;
            read_pos_reg   <= read_pos_next;
            write_pos_reg  <= write_pos_next;
            last_beat_reg  <= last_beat_next;
            underruns_reg  <= underruns_next;
            overruns_reg   <= overruns_next;
            delivered_reg  <= delivered_next;
            open_reg       <= open_next;
            n_reg          <= n_next;
            now_reg        <= now_next;
            age_reg        <= age_next;
            diff_reg       <= diff_next;
            alive_reg      <= alive_next;
            lapped_reg     <= lapped_next;
            avail_reg      <= avail_next;
            skip_sat_reg   <= skip_sat_next;
            base_reg       <= base_next;
            q_valid_reg    <= q_valid_next;
            q_real_reg     <= q_real_next;
            q_last_reg     <= q_last_next;
            out_valid_reg  <= out_valid_next;
            out_frame_reg  <= out_frame_next;
            out_real_reg   <= out_real_next;
            out_last_reg   <= out_last_next;
            out_nreal_reg  <= out_nreal_next;
            out_under_reg  <= out_under_next;
            out_over_reg   <= out_over_next;
            out_deliv_reg  <= out_deliv_next;
            out_open_reg   <= out_open_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/prc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module prc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
